>>> src/rqs_pkg.sv
// Shared types and codes of the ready queue scheduler: request and response
// beats, queue entry layout, command, status and register codes, sequencer states.
// No dependencies.
package rqs_pkg;

	localparam int QueueDepthDefault = 16;

	localparam logic [1:0] CmdEnqueue  = 2'd0;
	localparam logic [1:0] CmdEnd      = 2'd1;
	localparam logic [1:0] CmdDispatch = 2'd2;

	localparam logic [2:0] StatAccepted   = 3'd0;
	localparam logic [2:0] StatDispatched = 3'd1;
	localparam logic [2:0] StatWait       = 3'd2;
	localparam logic [2:0] StatDone       = 3'd3;
	localparam logic [2:0] StatFull       = 3'd4;

	localparam logic [1:0] PolicyFcfs = 2'd0;
	localparam logic [1:0] PolicySjf  = 2'd1;
	localparam logic [1:0] PolicyRr   = 2'd2;

	localparam logic CfgPolicyMode  = 1'b0;
	localparam logic CfgTimeQuantum = 1'b1;

	localparam logic [15:0] QuantumReset = 16'd20;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] proc_id;
		logic [15:0] burst_length;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] chosen_id;
		logic [15:0] slice_length;
		logic [15:0] time_left;
		logic        completed;
	} rsp_t;

	typedef struct packed {
		logic [15:0] ident;
		logic [15:0] burst;
		logic [15:0] remaining;
	} entry_t;

	typedef enum logic [2:0] {
		StIdle,
		StHeadData,
		StScan,
		StShift,
		StApply,
		StResult
	} state_t;

endpackage

>>> src/ready_queue_scheduler.sv
// Ready queue scheduler top level: circular entry memory, scan and shift sequencer,
// response register. Depends on rqs_pkg.
//
// Usage: commands arrive as req beats (valid/ready), one response beat per
// command leaves on rsp (valid/ready). Configuration is written through
// cfg_wr_en/cfg_addr/cfg_wdata while the block is idle: index 0 policy_mode,
// index 1 time_quantum.
// The block takes one command at a time; req_ready is high only while idle.
// Path from accepted beat to response register, by command:
//   enqueue, end, empty dispatch: straight to the result state
//   FCFS or RR dispatch: a memory read of the head, then the apply state
//   SJF dispatch: the single-port scan over all entries, followed by the shift
//   that closes the gap, one entry a cycle, then the apply state.
// A waiting response does not block the next command from being accepted;
// if the receiver stalls, the following response holds in the result state
// until the register frees, and req_ready stays low meanwhile.
// Reset clears the queue (occupancy zero), the end-of-input flag, the
// response valid and sets policy 0, quantum 20. The entry memory has no reset.
module ready_queue_scheduler #(
	parameter int QueueDepth = rqs_pkg::QueueDepthDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rqs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rqs_pkg::rsp_t rsp,
	input  logic          cfg_wr_en,
	input  logic          cfg_addr,
	input  logic [15:0]   cfg_wdata
);

	localparam int AddrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW  = $clog2(QueueDepth + 1);

	function automatic logic [AddrW-1:0] ptr_inc(input logic [AddrW-1:0] p);
		ptr_inc = (p == AddrW'(QueueDepth - 1)) ? '0 : p + AddrW'(1);
	endfunction

	function automatic logic [AddrW-1:0] ptr_dec(input logic [AddrW-1:0] p);
		ptr_dec = (p == '0) ? AddrW'(QueueDepth - 1) : p - AddrW'(1);
	endfunction

	rqs_pkg::state_t state_q, state_d;

	logic [1:0]       policy_q;
	logic [15:0]      quantum_q;
	logic [CntW-1:0]  occ_q;
	logic [AddrW-1:0] head_q, tail_q;
	logic             input_over_q;
	logic [CntW-1:0]  cnt_q;
	logic [AddrW-1:0] ptr_q;
	logic             issue_s1;
	logic [AddrW-1:0] ptr_s1;
	logic [CntW-1:0]  pos_s1;
	logic             first_q;
	rqs_pkg::entry_t  best_q;
	logic [CntW-1:0]  best_pos_q;
	logic [AddrW-1:0] best_ptr_q;
	rqs_pkg::entry_t  sel_q;
	rqs_pkg::rsp_t    res_q;
	rqs_pkg::rsp_t    rsp_q;
	logic             rsp_valid_q;
	logic [2:0]       idle_status;

	rqs_pkg::entry_t  entry_mem_q [QueueDepth];
	rqs_pkg::entry_t  rd_entry_q;
	logic [AddrW-1:0] mem_raddr, mem_waddr;
	logic             mem_we;
	rqs_pkg::entry_t  mem_wdata;

	logic full, rsp_free, requeue, walk_left, scan_exit, shift_exit;

	assign full       = (occ_q == CntW'(QueueDepth));
	assign rsp_free   = !rsp_valid_q || rsp_ready;
	assign requeue    = (policy_q == rqs_pkg::PolicyRr) && (sel_q.remaining > quantum_q);
	assign walk_left  = (cnt_q < occ_q);
	assign scan_exit  = !walk_left && !issue_s1;
	assign shift_exit = !walk_left && !issue_s1;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		priority if (req.cmd == rqs_pkg::CmdEnqueue && full) begin
			idle_status = rqs_pkg::StatFull;
		end else if (req.cmd == rqs_pkg::CmdDispatch && occ_q == '0) begin
			idle_status = input_over_q ? rqs_pkg::StatDone : rqs_pkg::StatWait;
		end else begin
			idle_status = rqs_pkg::StatAccepted;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem_q[mem_waddr] <= mem_wdata;
		end
		rd_entry_q <= entry_mem_q[mem_raddr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rqs_pkg::StIdle: begin
				if (req_valid) begin
					if (req.cmd == rqs_pkg::CmdDispatch && occ_q != '0) begin
						state_d = (policy_q == rqs_pkg::PolicySjf) ?
							rqs_pkg::StScan : rqs_pkg::StHeadData;
					end else begin
						state_d = rqs_pkg::StResult;
					end
				end
			end
			rqs_pkg::StHeadData: state_d = rqs_pkg::StApply;
			rqs_pkg::StScan: begin
				if (scan_exit) state_d = rqs_pkg::StShift;
			end
			rqs_pkg::StShift: begin
				if (shift_exit) state_d = rqs_pkg::StApply;
			end
			rqs_pkg::StApply: state_d = rqs_pkg::StResult;
			rqs_pkg::StResult: begin
				if (rsp_free) state_d = rqs_pkg::StIdle;
			end
			default: state_d = rqs_pkg::StIdle;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		mem_raddr = head_q;
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = rd_entry_q;
		unique case (state_q)
			rqs_pkg::StIdle: begin
				req_ready = 1'b1;
				mem_we    = req_valid && req.cmd == rqs_pkg::CmdEnqueue && !full;
				mem_wdata = '{ident: req.proc_id, burst: req.burst_length,
					remaining: req.burst_length};
			end
			rqs_pkg::StScan: mem_raddr = ptr_q;
			rqs_pkg::StShift: begin
				mem_raddr = ptr_q;
				mem_we    = issue_s1;
				mem_waddr = ptr_dec(ptr_s1);
			end
			rqs_pkg::StApply: begin
				mem_we    = requeue;
				mem_wdata = '{ident: sel_q.ident, burst: sel_q.burst,
					remaining: sel_q.remaining - quantum_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rqs_pkg::StIdle;
			policy_q     <= rqs_pkg::PolicyFcfs;
			quantum_q    <= rqs_pkg::QuantumReset;
			occ_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			input_over_q <= 1'b0;
			cnt_q        <= '0;
			ptr_q        <= '0;
			issue_s1     <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				unique case (cfg_addr)
					rqs_pkg::CfgPolicyMode:  policy_q  <= cfg_wdata[1:0];
					rqs_pkg::CfgTimeQuantum: quantum_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (state_q == rqs_pkg::StResult && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				rqs_pkg::StIdle: begin
					issue_s1 <= 1'b0;
					if (req_valid) begin
						if (req.cmd == rqs_pkg::CmdEnqueue && !full) begin
							tail_q <= ptr_inc(tail_q);
							occ_q  <= occ_q + CntW'(1);
						end
						if (req.cmd == rqs_pkg::CmdEnd) input_over_q <= 1'b1;
						cnt_q <= '0;
						ptr_q <= head_q;
					end
				end
				rqs_pkg::StHeadData: begin
					head_q <= ptr_inc(head_q);
					occ_q  <= occ_q - CntW'(1);
				end
				rqs_pkg::StScan: begin
					issue_s1 <= walk_left;
					if (walk_left) begin
						cnt_q <= cnt_q + CntW'(1);
						ptr_q <= ptr_inc(ptr_q);
					end
					if (scan_exit) begin
						cnt_q <= best_pos_q + CntW'(1);
						ptr_q <= ptr_inc(best_ptr_q);
					end
				end
				rqs_pkg::StShift: begin
					issue_s1 <= walk_left;
					if (walk_left) begin
						cnt_q <= cnt_q + CntW'(1);
						ptr_q <= ptr_inc(ptr_q);
					end
					if (shift_exit) begin
						tail_q <= ptr_dec(tail_q);
						occ_q  <= occ_q - CntW'(1);
					end
				end
				rqs_pkg::StApply: begin
					if (requeue) begin
						tail_q <= ptr_inc(tail_q);
						occ_q  <= occ_q + CntW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ptr_s1 <= ptr_q;
		pos_s1 <= cnt_q;
		unique case (state_q)
			rqs_pkg::StIdle: begin
				first_q <= 1'b1;
				res_q   <= '{status: idle_status, chosen_id: '0, slice_length: '0,
					time_left: '0, completed: 1'b0};
			end
			rqs_pkg::StHeadData: sel_q <= rd_entry_q;
			rqs_pkg::StScan: begin
				if (issue_s1 && (first_q || rd_entry_q.burst < best_q.burst)) begin
					best_q     <= rd_entry_q;
					best_pos_q <= pos_s1;
					best_ptr_q <= ptr_s1;
					first_q    <= 1'b0;
				end
			end
			rqs_pkg::StShift: sel_q <= best_q;
			rqs_pkg::StApply: begin
				res_q.status    <= rqs_pkg::StatDispatched;
				res_q.chosen_id <= sel_q.ident;
				if (requeue) begin
					res_q.slice_length <= quantum_q;
					res_q.time_left    <= sel_q.remaining - quantum_q;
					res_q.completed    <= 1'b0;
				end else begin
					res_q.slice_length <= sel_q.remaining;
					res_q.time_left    <= '0;
					res_q.completed    <= 1'b1;
				end
			end
			rqs_pkg::StResult: begin
				if (rsp_free) rsp_q <= res_q;
			end
			default: ;
		endcase
	end

endmodule

>>> sim/ready_queue_scheduler_test.sv
// Self-checking testbench for ready_queue_scheduler: directed and random command traffic
// with random idles on both sides, checked against an in-bench queue predictor.
// Depends on rqs_pkg and the ready_queue_scheduler RTL.
`timescale 1ns / 1ps

module ready_queue_scheduler_test;

	localparam logic [1:0] CmdUnused = 2'd3;
	localparam logic [1:0] PolicyUnused = 2'd3;
	localparam int SettleCycles = 60;
	localparam int CycleLimit = 1_000_000;
	localparam int RandomBeats = 880;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	rqs_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	rqs_pkg::rsp_t rsp;
	logic          cfg_wr_en = 1'b0;
	logic          cfg_addr = 1'b0;
	logic [15:0]   cfg_wdata = '0;

	rqs_pkg::entry_t shadow_queue[$];
	rqs_pkg::rsp_t   sched_outcomes[$];
	rqs_pkg::rsp_t   want_rsp;
	logic [1:0]      policy_sel = rqs_pkg::PolicyFcfs;
	logic [15:0]     quantum_len = rqs_pkg::QuantumReset;
	logic            end_seen = 1'b0;
	logic            quiet = 1'b0;
	int              stall_left = 0;
	int              beats_sent = 0;
	int              fail_count = 0;
	int              cycle_count = 0;

	ready_queue_scheduler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_burst();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 16'($urandom_range(0, 60));
		if (r < 75) return 16'd0;
		if (r < 90) return 16'($urandom);
		return 16'hFFFF;
	endfunction

	function automatic rqs_pkg::rsp_t predict_schedule(input rqs_pkg::req_t beat);
		rqs_pkg::rsp_t res;
		rqs_pkg::entry_t e;
		int pos;
		int i;
		res = '0;
		res.status = rqs_pkg::StatAccepted;
		case (beat.cmd)
			rqs_pkg::CmdEnqueue: begin
				if (shadow_queue.size() >= rqs_pkg::QueueDepthDefault)
					res.status = rqs_pkg::StatFull;
				else
					shadow_queue.push_back(rqs_pkg::entry_t'{beat.proc_id,
						beat.burst_length, beat.burst_length});
			end
			rqs_pkg::CmdEnd: begin
				end_seen = 1'b1;
			end
			rqs_pkg::CmdDispatch: begin
				if (shadow_queue.size() == 0) begin
					res.status = end_seen ? rqs_pkg::StatDone : rqs_pkg::StatWait;
				end else begin
					pos = 0;
					if (policy_sel == rqs_pkg::PolicySjf)
						for (i = 1; i < shadow_queue.size(); i++)
							if (shadow_queue[i].burst < shadow_queue[pos].burst)
								pos = i;
					e = shadow_queue[pos];
					shadow_queue.delete(pos);
					res.status = rqs_pkg::StatDispatched;
					res.chosen_id = e.ident;
					if (policy_sel == rqs_pkg::PolicyRr && e.remaining > quantum_len) begin
						res.slice_length = quantum_len;
						res.time_left = e.remaining - quantum_len;
						e.remaining = e.remaining - quantum_len;
						shadow_queue.push_back(e);
					end else begin
						res.slice_length = e.remaining;
						res.completed = 1'b1;
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic send_beat(input logic [1:0] op, input logic [15:0] id,
			input logic [15:0] bl);
		int gap;
		rqs_pkg::req_t beat;
		gap = pick_gap();
		beat.cmd = op;
		beat.proc_id = id;
		beat.burst_length = bl;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= beat;
		do @(posedge clk); while (!req_ready);
		sched_outcomes.push_back(predict_schedule(beat));
		beats_sent++;
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (sched_outcomes.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic addr, input logic [15:0] data);
		cfg_wr_en <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (addr == rqs_pkg::CfgPolicyMode)
			policy_sel = data[1:0];
		else
			quantum_len = data;
	endtask

	task automatic check_field(input string fname, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (sched_outcomes.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual %p", $time, rsp);
				fail_count++;
			end else begin
				want_rsp = sched_outcomes.pop_front();
				check_field("status", want_rsp.status, rsp.status);
				check_field("chosen_id", want_rsp.chosen_id, rsp.chosen_id);
				check_field("slice_length", want_rsp.slice_length, rsp.slice_length);
				check_field("time_left", want_rsp.time_left, rsp.time_left);
				check_field("completed", want_rsp.completed, rsp.completed);
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			rsp_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (quiet || $urandom_range(0, 99) < 70) begin
			rsp_ready <= 1'b1;
		end else begin
			rsp_ready <= 1'b0;
			stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic test_fcfs_order();
		send_beat(rqs_pkg::CmdDispatch, 16'h0000, 16'h0000);
		send_beat(rqs_pkg::CmdEnqueue, 16'h0000, 16'h0000);
		send_beat(rqs_pkg::CmdEnqueue, 16'hFFFF, 16'hFFFF);
		send_beat(rqs_pkg::CmdEnqueue, 16'h5555, 16'hAAAA);
		send_beat(rqs_pkg::CmdEnqueue, 16'hAAAA, 16'h5555);
		send_beat(CmdUnused, 16'hFFFF, 16'hFFFF);
		send_beat(rqs_pkg::CmdDispatch, 16'h0000, 16'h0000);
		send_beat(rqs_pkg::CmdDispatch, 16'h0000, 16'h0000);
		settle();
	endtask

	task automatic test_sjf_ties();
		write_reg(rqs_pkg::CfgPolicyMode, {14'd0, rqs_pkg::PolicySjf});
		send_beat(rqs_pkg::CmdEnqueue, 16'h0007, 16'h5555);
		send_beat(rqs_pkg::CmdDispatch, 16'h0000, 16'h0000);
		send_beat(rqs_pkg::CmdDispatch, 16'h0000, 16'h0000);
		settle();
	endtask

	task automatic test_rr_slices();
		write_reg(rqs_pkg::CfgPolicyMode, {14'd0, rqs_pkg::PolicyRr});
		write_reg(rqs_pkg::CfgTimeQuantum, 16'd0);
		send_beat(rqs_pkg::CmdEnqueue, 16'h1234, 16'd30);
		send_beat(rqs_pkg::CmdDispatch, 16'h0000, 16'h0000);
		settle();
		write_reg(rqs_pkg::CfgTimeQuantum, 16'd1);
		send_beat(rqs_pkg::CmdDispatch, 16'h0000, 16'h0000);
		settle();
		write_reg(rqs_pkg::CfgTimeQuantum, 16'hFFFF);
		send_beat(rqs_pkg::CmdDispatch, 16'h0000, 16'h0000);
		send_beat(rqs_pkg::CmdDispatch, 16'h0000, 16'h0000);
		settle();
	endtask

	task automatic test_random_traffic();
		int r;
		int k;
		int run_len;
		int stop_at;
		logic [15:0] word;
		stop_at = beats_sent + RandomBeats;
		while (beats_sent < stop_at) begin
			quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 9);
			word = 16'($urandom);
			word[1:0] = (r < 3) ? rqs_pkg::PolicyFcfs : (r < 6) ? rqs_pkg::PolicySjf :
				(r < 9) ? rqs_pkg::PolicyRr : PolicyUnused;
			write_reg(rqs_pkg::CfgPolicyMode, word);
			r = $urandom_range(0, 9);
			word = (r == 0) ? 16'd0 : (r == 1) ? 16'd1 : (r == 2) ? 16'hFFFF :
				(r == 3) ? 16'($urandom) : 16'($urandom_range(2, 40));
			write_reg(rqs_pkg::CfgTimeQuantum, word);
			run_len = $urandom_range(20, 60);
			for (k = 0; k < run_len; k++) begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					send_beat(rqs_pkg::CmdEnqueue, 16'($urandom), pick_burst());
				end else if (r < 88) begin
					send_beat(rqs_pkg::CmdDispatch, 16'($urandom), 16'($urandom));
				end else if (r < 93) begin
					if (beats_sent > stop_at - RandomBeats / 2)
						send_beat(rqs_pkg::CmdEnd, 16'($urandom), 16'($urandom));
					else
						send_beat(rqs_pkg::CmdDispatch, 16'($urandom), 16'($urandom));
				end else if (r < 96) begin
					send_beat(CmdUnused, 16'($urandom), 16'($urandom));
				end else begin
					repeat (rqs_pkg::QueueDepthDefault + 1)
						send_beat(rqs_pkg::CmdEnqueue, 16'($urandom), pick_burst());
				end
			end
			settle();
		end
		quiet = 1'b0;
	endtask

	task automatic test_end_of_input();
		write_reg(rqs_pkg::CfgPolicyMode, {14'd0, PolicyUnused});
		send_beat(rqs_pkg::CmdEnqueue, 16'h0002, 16'h0000);
		send_beat(rqs_pkg::CmdEnd, 16'h0000, 16'h0000);
		send_beat(rqs_pkg::CmdEnd, 16'hFFFF, 16'hFFFF);
		repeat (rqs_pkg::QueueDepthDefault + 1)
			send_beat(rqs_pkg::CmdDispatch, 16'h0000, 16'h0000);
		send_beat(rqs_pkg::CmdEnqueue, 16'h0003, 16'h0009);
		send_beat(rqs_pkg::CmdDispatch, 16'h0000, 16'h0000);
		send_beat(rqs_pkg::CmdDispatch, 16'h0000, 16'h0000);
		settle();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fcfs_order();
		test_sjf_ties();
		test_rr_slices();
		test_random_traffic();
		test_end_of_input();
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
